>>> src/kr64_pkg.sv
// Package for the keyed radix-64 encoder: transaction structs, item and
// register codes, and the sizes shared by the top level, its RAMs and its checker.
// Depends on nothing.
package kr64_pkg;

   localparam int KEY_DEPTH_DEFAULT = 64;
   localparam int TABLE_DEPTH       = 64;
   localparam int GROUP_W           = 6;
   localparam int SYMBOL_W          = 8;
   localparam int KEY_LENGTH_W      = 7;
   localparam int MODE_W            = 2;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 7;
   localparam int RSP_FIFO_DEPTH    = 4;

   // Item kinds.
   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_TABLE_WR = 2'd1;
   localparam logic [1:0] KIND_KEY_WR   = 2'd2;
   localparam logic [1:0] KIND_END      = 2'd3;

   // Encoding modes.
   localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUB   = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 2'd1;

   typedef struct packed {
      logic [1:0]          kind;
      logic [5:0]          index;
      logic [7:0]          value;
   } req_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                has_symbol;
      logic                string_done;
      logic                run_last;
   } rsp_type;

endpackage

>>> src/kr64_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the symbol table and the key store. No package dependency.
module kr64_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/keyed_radix64_encoder_top.sv
// Top level of the keyed radix-64 encoder: issue logic, key and table pipeline,
// result queue and configuration registers. Depends on kr64_pkg and kr64_ram.
//
// Usage
// The request channel (req_valid, req_stall, req_data) carries one item per
// transaction: a data byte, a symbol table write, a key character write or an
// end of string. The response channel (rsp_valid, rsp_stall, rsp_data) returns
// the encoded symbols; run_last marks the final response of an item and
// string_done the response to an end item. The csr channel writes the mode and
// the key length and is always ready; the user must write it only while the block
// idles, and the block does not enforce this. The first response of an item passes
// through the key store read, the symbol table read and then the response queue;
// the second response of a completed byte triple follows it.
// Throughput: one item per cycle while the response queue has room, except a data
// byte that completes a three-byte group, which issues two groups and so holds the
// issue stage for the second one too. The single read port of each RAM sets that
// figure: one group passes through the key store and the symbol table per cycle.
// Reset clears the carry, byte phase, key pointer, registers and the response
// queue; the symbol table and key store hold nothing valid until written.
// When the receiver stalls, responses wait in a four-entry queue; requests are
// stalled once the queue together with the groups in flight would fill it.
module keyed_radix64_encoder_top #(
   parameter int KEY_DEPTH = kr64_pkg::KEY_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  kr64_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output kr64_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kr64_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kr64_pkg::CSR_DATA_W-1:0]     csr_data
);

   import kr64_pkg::*;

   // Key pointer width and a width wide enough to compare it with the length.
   localparam int PW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int LW   = ((PW + 1) > KEY_LENGTH_W) ? (PW + 1) : KEY_LENGTH_W;
   localparam int TAW  = $clog2(TABLE_DEPTH);
   localparam int QAW  = $clog2(RSP_FIFO_DEPTH);
   localparam int QCW  = QAW + 1;

   // One group or table write travelling from the key read to the table read.
   typedef struct packed {
      logic                is_result;
      logic                is_table_wr;
      logic [GROUP_W-1:0]  group;
      logic                has_symbol;
      logic                string_done;
      logic                run_last;
      logic [TAW-1:0]      tw_index;
      logic [SYMBOL_W-1:0] tw_value;
   } stage1_type;

   typedef struct packed {
      logic                valid;
      logic                has_symbol;
      logic                string_done;
      logic                run_last;
   } stage2_type;

   // Configuration registers.
   logic [MODE_W-1:0]       mode_ff;
   logic [KEY_LENGTH_W-1:0] key_length_ff;

   // Encoder state.
   logic [3:0]              carry_ff, carry_in;
   logic [1:0]              phase_ff, phase_in;
   logic [PW-1:0]           key_pointer_ff, key_pointer_in;
   logic                    pending_ff, pending_in;
   logic [GROUP_W-1:0]      pend_group_ff, pend_group_in;

   stage1_type              s1_ff, s1_in;
   stage2_type              s2_ff, s2_in;

   // Response queue.
   rsp_type                 queue_ff [RSP_FIFO_DEPTH];
   logic [QAW-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0]          count_ff, count_in;

   logic                    accept;
   logic                    pend_issue;
   logic                    credit_ok;
   logic [QCW:0]            used;
   logic [1:0]              phase_eff;
   logic [11:0]             data_word;
   logic [PW-1:0]           pointer_next;
   logic [LW-1:0]           eff_len;
   logic [PW+5:0]           key_idx_wide;
   logic                    key_wr_en;
   logic [GROUP_W-1:0]      key_rdata;
   logic [GROUP_W-1:0]      group_keyed;
   logic [SYMBOL_W-1:0]     table_rdata;
   logic                    push, pop;
   rsp_type                 push_entry;

   // ---------------------------------------------------------------------
   // Issue stage: takes a request or the second group of a completed byte
   // triple, and updates the carry, phase and key pointer at once.
   // ---------------------------------------------------------------------
   assign used      = (QCW + 1)'(count_ff) + (QCW + 1)'(s1_ff.is_result)
                      + (QCW + 1)'(s2_ff.valid);
   assign credit_ok = used < (QCW + 1)'(RSP_FIFO_DEPTH);
   assign req_stall = pending_ff || !credit_ok;
   assign accept    = req_valid && !req_stall;
   assign pend_issue = pending_ff && credit_ok;

   assign phase_eff = (phase_ff == 2'd3) ? 2'd0 : phase_ff;
   assign data_word = ({4'b0, req_data.value} << {phase_eff, 1'b0}) | {8'b0, carry_ff};

   // Effective key length, clamped to 1..KEY_DEPTH, and the advanced pointer.
   always_comb begin
      eff_len = LW'(key_length_ff);
      if (eff_len == '0) begin
         eff_len = LW'(1);
      end else if (eff_len > LW'(KEY_DEPTH)) begin
         eff_len = LW'(KEY_DEPTH);
      end
   end

   always_comb begin
      logic [LW-1:0] next_wide;
      next_wide = LW'(key_pointer_ff) + LW'(1);
      if (next_wide >= eff_len) begin
         pointer_next = '0;
      end else begin
         pointer_next = next_wide[PW-1:0];
      end
   end

   always_comb begin
      carry_in       = carry_ff;
      phase_in       = phase_ff;
      key_pointer_in = key_pointer_ff;
      pending_in     = pending_ff;
      pend_group_in  = pend_group_ff;

      s1_in             = '0;
      s1_in.tw_index    = req_data.index;
      s1_in.tw_value    = req_data.value;

      if (pend_issue) begin
         s1_in.is_result   = 1'b1;
         s1_in.group       = pend_group_ff;
         s1_in.has_symbol  = 1'b1;
         s1_in.run_last    = 1'b1;
         key_pointer_in    = pointer_next;
         pending_in        = 1'b0;
      end else if (accept) begin
         unique case (req_data.kind)
            KIND_DATA: begin
               s1_in.is_result  = 1'b1;
               s1_in.group      = data_word[5:0];
               s1_in.has_symbol = 1'b1;
               key_pointer_in   = pointer_next;
               if (phase_eff == 2'd2) begin
                  s1_in.run_last = 1'b0;
                  pending_in     = 1'b1;
                  pend_group_in  = data_word[11:6];
                  carry_in       = '0;
                  phase_in       = '0;
               end else begin
                  s1_in.run_last = 1'b1;
                  carry_in       = data_word[9:6];
                  phase_in       = phase_eff + 2'd1;
               end
            end
            KIND_TABLE_WR: begin
               s1_in.is_table_wr = 1'b1;
            end
            KIND_KEY_WR: begin
               // Written straight into the key store below.
            end
            KIND_END: begin
               s1_in.is_result   = 1'b1;
               s1_in.group       = {2'b0, carry_ff};
               s1_in.has_symbol  = carry_ff != '0;
               s1_in.string_done = 1'b1;
               s1_in.run_last    = 1'b1;
               carry_in          = '0;
               phase_in          = '0;
               key_pointer_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Key writes beyond the key store are dropped.
   assign key_idx_wide = (PW + 6)'(req_data.index);
   assign key_wr_en    = accept && (req_data.kind == KIND_KEY_WR)
                         && (key_idx_wide < (PW + 6)'(KEY_DEPTH));

   // The key store is read at the current pointer on every cycle; the entry
   // belongs to whichever group is issued in that cycle.
   kr64_ram #(
      .WIDTH (GROUP_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_idx_wide[PW-1:0]),
      .wr_data (req_data.value[GROUP_W-1:0]),
      .rd_addr (key_pointer_ff),
      .rd_data (key_rdata)
   );

   // ---------------------------------------------------------------------
   // Stage 1: key character arrives; the group is offset and the symbol
   // table is read. Table writes are applied here so that they stay in order
   // with the reads of the items around them.
   // ---------------------------------------------------------------------
   always_comb begin
      case (mode_ff)
         MODE_ADD: group_keyed = s1_ff.group + key_rdata;
         MODE_SUB: group_keyed = s1_ff.group - key_rdata;
         default:  group_keyed = s1_ff.group;
      endcase
   end

   kr64_ram #(
      .WIDTH (SYMBOL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_symbol_table (
      .clock   (clock),
      .wr_en   (s1_ff.is_table_wr),
      .wr_addr (s1_ff.tw_index),
      .wr_data (s1_ff.tw_value),
      .rd_addr (group_keyed),
      .rd_data (table_rdata)
   );

   assign s2_in.valid       = s1_ff.is_result;
   assign s2_in.has_symbol  = s1_ff.has_symbol;
   assign s2_in.string_done = s1_ff.string_done;
   assign s2_in.run_last    = s1_ff.run_last;

   // ---------------------------------------------------------------------
   // Stage 2: the symbol is pushed into the response queue.
   // ---------------------------------------------------------------------
   assign push                   = s2_ff.valid;
   assign push_entry.symbol      = s2_ff.has_symbol ? table_rdata : '0;
   assign push_entry.has_symbol  = s2_ff.has_symbol;
   assign push_entry.string_done = s2_ff.string_done;
   assign push_entry.run_last    = s2_ff.run_last;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_PLAIN;
         key_length_ff  <= KEY_LENGTH_W'(1);
         carry_ff       <= '0;
         phase_ff       <= '0;
         key_pointer_ff <= '0;
         pending_ff     <= 1'b0;
         s1_ff          <= '0;
         s2_ff          <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODE:       mode_ff       <= csr_data[MODE_W-1:0];
               CSR_KEY_LENGTH: key_length_ff <= csr_data[KEY_LENGTH_W-1:0];
               default: begin
               end
            endcase
         end
         carry_ff       <= carry_in;
         phase_ff       <= phase_in;
         key_pointer_ff <= key_pointer_in;
         pending_ff     <= pending_in;
         s1_ff          <= s1_in;
         s2_ff          <= s2_in;
         count_ff       <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      pend_group_ff <= pend_group_in;
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/kr64_checker.sv
// Port-level checker for the keyed radix-64 encoder, bound to its top level.
// Depends on kr64_pkg and keyed_radix64_encoder_top.
module kr64_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input kr64_pkg::rsp_type rsp_data
);

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // The response that closes a string is always the last of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_done |-> rsp_data.run_last)
      else $error("string end not marked as last response");

   // An empty response only closes a string and carries a zero symbol.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_symbol |->
         rsp_data.string_done && (rsp_data.symbol == '0))
      else $error("empty response outside string end");

   // The first of two responses is a data symbol, not a string end; the second
   // response follows it once it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.run_last |->
         rsp_data.has_symbol && !rsp_data.string_done)
      else $error("inner response marked as string end");

endmodule

bind keyed_radix64_encoder_top kr64_checker u_kr64_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> verif/kr64_checker.sv
`timescale 1ns / 100ps
// Response checker for the keyed radix-64 encoder: watches the request, response
// and csr channels, predicts every response and compares it field by field.
// Depends on kr64_pkg only.
module kr64_tb_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  kr64_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  kr64_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [kr64_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kr64_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               error_count,
   output int                               pending_count
);

   import kr64_pkg::*;

   logic [MODE_W-1:0]       enc_mode;
   logic [KEY_LENGTH_W-1:0] key_len;
   logic [3:0]              carry;
   logic [1:0]              phase;
   logic [5:0]              key_ptr;
   logic [SYMBOL_W-1:0]     symbols [TABLE_DEPTH];
   logic [GROUP_W-1:0]      key_chars [KEY_DEPTH_DEFAULT];
   rsp_type                 expected_symbols [$];
   rsp_type                 want;
   int                      errors = 0;

   // Offsets a 6-bit group by the current key character as the mode selects, and looks it up.
   function automatic logic [SYMBOL_W-1:0] map_group(input logic [GROUP_W-1:0] grp);
      logic [GROUP_W-1:0] k;
      logic [GROUP_W-1:0] g;
      k = key_chars[key_ptr];
      case (enc_mode)
         MODE_ADD: g = grp + k;
         MODE_SUB: g = grp - k;
         default:  g = grp;
      endcase
      return symbols[g];
   endfunction

   // The pointer wraps at the key length, clamped to 1..KEY_DEPTH.
   function automatic logic [5:0] next_key_ptr(input logic [5:0] ptr,
                                               input logic [KEY_LENGTH_W-1:0] len);
      int span;
      int nxt;
      span = (len == 0) ? 1 : (len > KEY_DEPTH_DEFAULT) ? KEY_DEPTH_DEFAULT : int'(len);
      nxt  = int'(ptr) + 1;
      return (nxt >= span) ? 6'd0 : nxt[5:0];
   endfunction

   task automatic push_symbol(input logic [SYMBOL_W-1:0] sym, input logic has,
                              input logic done, input logic last);
      rsp_type r;
      r.symbol      = sym;
      r.has_symbol  = has;
      r.string_done = done;
      r.run_last    = last;
      expected_symbols.push_back(r);
   endtask

   task automatic predict_item(input req_type item);
      logic [15:0]         bits;
      logic [1:0]          ph;
      logic [SYMBOL_W-1:0] first;
      case (item.kind)
         KIND_TABLE_WR: symbols[item.index] = item.value;
         KIND_KEY_WR:   key_chars[item.index] = item.value[GROUP_W-1:0];
         KIND_END: begin
            // Leftover bits give a symbol only when they are nonzero.
            if (carry != 4'd0) push_symbol(map_group({2'b00, carry}), 1'b1, 1'b1, 1'b1);
            else push_symbol('0, 1'b0, 1'b1, 1'b1);
            carry   = '0;
            phase   = '0;
            key_ptr = '0;
         end
         default: begin
            ph    = (phase > 2'd2) ? 2'd0 : phase;
            bits  = ({8'h00, item.value} << (2 * ph)) | {12'h000, carry};
            first = map_group(bits[5:0]);
            key_ptr = next_key_ptr(key_ptr, key_len);
            if (ph == 2'd2) begin
               push_symbol(first, 1'b1, 1'b0, 1'b0);
               push_symbol(map_group(bits[11:6]), 1'b1, 1'b0, 1'b1);
               key_ptr = next_key_ptr(key_ptr, key_len);
               carry   = '0;
               phase   = '0;
            end else begin
               push_symbol(first, 1'b1, 1'b0, 1'b1);
               carry = bits[9:6];
               phase = ph + 2'd1;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [SYMBOL_W-1:0] exp_val,
                              input logic [SYMBOL_W-1:0] got_val);
      if (got_val !== exp_val) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_symbols.delete();
         enc_mode = MODE_PLAIN;
         key_len  = 7'd1;
         carry    = '0;
         phase    = '0;
         key_ptr  = '0;
      end else begin
         // Responses first, so that a request at the same edge cannot hide a
         // response that nothing asked for.
         if (rsp_valid && !rsp_stall) begin
            if (expected_symbols.size() == 0) begin
               errors++;
               $display("%0t: response %0h with none expected", $time, rsp_data);
            end else begin
               want = expected_symbols.pop_front();
               check_field("symbol", want.symbol, rsp_data.symbol);
               check_field("has_symbol", SYMBOL_W'(want.has_symbol),
                           SYMBOL_W'(rsp_data.has_symbol));
               check_field("string_done", SYMBOL_W'(want.string_done),
                           SYMBOL_W'(rsp_data.string_done));
               check_field("run_last", SYMBOL_W'(want.run_last),
                           SYMBOL_W'(rsp_data.run_last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:       enc_mode = csr_data[MODE_W-1:0];
               CSR_KEY_LENGTH: key_len  = csr_data[KEY_LENGTH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_item(req_data);
      end
      error_count   <= errors;
      pending_count <= expected_symbols.size();
   end

endmodule

>>> verif/tb_keyed_radix64_encoder_top.sv
`timescale 1ns / 100ps
// Testbench top for the keyed radix-64 encoder: makes the stimulus on the request,
// response and csr channels and gives the verdict. Depends on kr64_pkg,
// kr64_tb_checker and keyed_radix64_encoder_top.
module tb_keyed_radix64_encoder_top;
   import kr64_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int LONG_HOLD       = 150;
   localparam int SETTLE          = 8;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 115;

   // Codes that the block does not name but the fields can carry.
   localparam logic [MODE_W-1:0]      MODE_SPARE  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   int                     error_count;
   int                     pending_count;

   bit req_gaps_on   = 1'b0;
   bit rsp_gaps_on   = 1'b0;
   int long_hold_req = 0;
   int hold_seen     = 0;
   bit rsp_fired     = 1'b0;
   int hold_left     = 0;
   int stall_left    = 0;
   int cycle_count   = 0;

   // Settings for the random phases: every mode including the unused one, and
   // key lengths at and beyond both ends of the legal range.
   logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_ADD, MODE_SUB, MODE_PLAIN, MODE_ADD,
                                              MODE_SUB, MODE_SPARE, MODE_ADD, MODE_SUB,
                                              MODE_ADD, MODE_SUB, MODE_PLAIN, MODE_ADD};
   int                phase_len  [PHASES] = '{64, 1, 17, 0, 65, 5, 127, 2, 63, 3, 64, 33};

   keyed_radix64_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   kr64_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Watchdog: a run that hangs or loses responses ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_keyed_radix64_encoder_top NOT OK");
         $finish;
      end
   end

   // When enabled, half of the draws give no wait and the rest a random nonzero wait.
   function automatic int draw_wait(input bit enabled);
      if (!enabled || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 16);
   endfunction

   function automatic req_type make_item(input logic [1:0] kind, input logic [5:0] index,
                                         input logic [7:0] value);
      req_type item;
      item.kind  = kind;
      item.index = index;
      item.value = value;
      return item;
   endfunction

   // Remembers whether a response transaction completed at the last rising edge,
   // so that the receiver draws a fresh wait once per response.
   always @(posedge clock) rsp_fired <= !reset && rsp_valid && !rsp_stall;

   // Receiver. A long hold, when requested by the stimulus, is counted down here
   // and overrides the ordinary per-response waits.
   always @(negedge clock) begin
      if (long_hold_req != hold_seen) begin
         hold_seen = long_hold_req;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_fired) stall_left = draw_wait(rsp_gaps_on);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one item and returns at the rising edge where it was taken. Valid is
   // left high, so that a following item with no gap keeps it high without a
   // second assignment in the same time step.
   task automatic send_item(input req_type item);
      int gap;
      gap = draw_wait(req_gaps_on);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Lowers valid and waits until every expected response has come back, then lets
   // the pipeline settle, since a write item still in the pipeline shows no response.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // The mode register only keeps the low bits; the rest of the data is noise.
   task automatic configure(input logic [MODE_W-1:0] mode, input int len);
      logic [CSR_DATA_W-MODE_W-1:0] junk;
      junk = (CSR_DATA_W - MODE_W)'($urandom_range(0, 31));
      write_csr(CSR_MODE, {junk, mode});
      write_csr(CSR_KEY_LENGTH, len[CSR_DATA_W-1:0]);
   endtask

   // One string: data bytes with an occasional table or key write in between,
   // usually closed by an end item. The budget counts every item sent and may
   // run out mid-string, which leaves the string open into the next phase.
   task automatic send_string(input int length, inout int budget);
      for (int i = 0; i < length && budget > 0; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(make_item($urandom_range(0, 1) ? KIND_TABLE_WR : KIND_KEY_WR,
                                6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))));
            budget--;
         end
         send_item(make_item(KIND_DATA, 6'($urandom_range(0, 63)),
                             8'($urandom_range(0, 255))));
         budget--;
      end
      if (budget > 0 && $urandom_range(0, 9) != 0) begin
         send_item(make_item(KIND_END, 6'($urandom_range(0, 63)),
                             8'($urandom_range(0, 255))));
         budget--;
      end
   endtask

   // Mostly short strings, some empty ones (back-to-back end items) and a few
   // long enough to wrap the key pointer at the largest key length.
   task automatic run_strings(input int budget);
      int length;
      while (budget > 0) begin
         case ($urandom_range(0, 9))
            0:       length = $urandom_range(20, 70);
            1:       length = 0;
            default: length = $urandom_range(1, 9);
         endcase
         send_string(length, budget);
      end
   endtask

   initial begin
      // Synchronous reset, held from the start and released on a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill both stores completely, so that no lookup ever touches an entry
      // that was never written.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_item(make_item(KIND_TABLE_WR, i[5:0], 8'($urandom_range(0, 255))));
         send_item(make_item(KIND_KEY_WR, i[5:0], 8'($urandom_range(0, 255))));
      end

      // Directed transactions in the reset settings (plain mode, one key).
      // An end item on an empty string.
      send_item(make_item(KIND_END, 6'd0, 8'h00));
      // A full three-byte group, so the end finds no leftover bits.
      send_item(make_item(KIND_DATA, 6'd63, 8'h00));
      send_item(make_item(KIND_DATA, 6'd0, 8'hff));
      send_item(make_item(KIND_DATA, 6'd21, 8'h80));
      send_item(make_item(KIND_END, 6'd63, 8'hff));
      // One byte with nonzero top bits: a 2-bit leftover is flushed.
      send_item(make_item(KIND_DATA, 6'd0, 8'hff));
      send_item(make_item(KIND_END, 6'd0, 8'h00));
      // One byte whose top bits are clear: the 2-bit leftover is zero.
      send_item(make_item(KIND_DATA, 6'd0, 8'h3f));
      send_item(make_item(KIND_END, 6'd0, 8'h00));
      // Two bytes leaving a nonzero 4-bit leftover.
      send_item(make_item(KIND_DATA, 6'd0, 8'h12));
      send_item(make_item(KIND_DATA, 6'd0, 8'hff));
      send_item(make_item(KIND_END, 6'd0, 8'h00));
      // Two bytes leaving a zero 4-bit leftover.
      send_item(make_item(KIND_DATA, 6'd0, 8'h01));
      send_item(make_item(KIND_DATA, 6'd0, 8'h0f));
      send_item(make_item(KIND_END, 6'd0, 8'h00));
      // Writes at both ends of the stores; the key keeps only its low six bits.
      send_item(make_item(KIND_TABLE_WR, 6'd63, 8'hff));
      send_item(make_item(KIND_TABLE_WR, 6'd0, 8'h00));
      send_item(make_item(KIND_KEY_WR, 6'd63, 8'hff));
      send_item(make_item(KIND_KEY_WR, 6'd0, 8'hc0));
      // All-ones and all-zeros groups read the entries just written.
      send_item(make_item(KIND_DATA, 6'd0, 8'hff));
      send_item(make_item(KIND_DATA, 6'd0, 8'hff));
      send_item(make_item(KIND_DATA, 6'd0, 8'hff));
      send_item(make_item(KIND_DATA, 6'd0, 8'h00));
      send_item(make_item(KIND_END, 6'd0, 8'h00));

      // Random phases, each under its own settings. Registers change only when
      // the block has drained; strings left open carry their key pointer across
      // a change of key length.
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         configure(phase_mode[p], phase_len[p]);
         if (p == 6) begin
            write_csr(CSR_SPARE_A, 7'($urandom_range(0, 127)));
            write_csr(CSR_SPARE_B, 7'($urandom_range(0, 127)));
         end
         req_gaps_on = (p % 3) != 1;
         rsp_gaps_on = (p % 4) != 2;
         if (p == 4) begin
            // Back pressure: the receiver holds off while the sender keeps
            // offering back-to-back items, so the response queue fills and the
            // block has to stall its request side.
            req_gaps_on = 1'b0;
            long_hold_req++;
         end
         run_strings(ITEMS_PER_PHASE);
         if (p % 2 == 0) begin
            repeat (2)
               send_item(make_item(KIND_DATA, 6'($urandom_range(0, 63)),
                                   8'($urandom_range(0, 255))));
         end
      end
      wait_idle();

      if (error_count == 0) begin
         $display("tb_keyed_radix64_encoder_top OK");
      end else begin
         $display("tb_keyed_radix64_encoder_top NOT OK");
      end
      $finish;
   end

endmodule
